// ===== rtl/core/rau_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rau_pkg;

    // Result bounds: numerator fits signed RAU_DW bits, denominator 1 .. 2^(RAU_DW-1)-1.
    localparam int RAU_DW = 32;
    localparam logic [63:0] RAU_LIM = 64'd1 << (RAU_DW - 1);

    localparam logic [2:0] OP_RED = 3'd0;
    localparam logic [2:0] OP_ADD = 3'd1;
    localparam logic [2:0] OP_SUB = 3'd2;
    localparam logic [2:0] OP_MUL = 3'd3;
    localparam logic [2:0] OP_DIV = 3'd4;
    localparam logic [2:0] OP_CMP = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_INVAL = 2'd1;
    localparam logic [1:0] ST_ZDIV  = 2'd2;
    localparam logic [1:0] ST_OVFL  = 2'd3;

    localparam logic [1:0] ORD_EQ = 2'b00;
    localparam logic [1:0] ORD_GT = 2'b01;
    localparam logic [1:0] ORD_LT = 2'b11;

    typedef logic [4:0] t_state;

endpackage

`default_nettype wire

// ===== rtl/core/rational_arithmetic_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Rational arithmetic unit. A request is taken when start is high and busy is low; it carries
// an operation (reduce, add, subtract, multiply, divide, compare) and one or two rationals.
// Exactly one result follows, shown for a single cycle with o_done high; the receiver cannot
// stall it, so it must capture the result in that cycle. An invalid operand or zero divisor
// is reported without leaving idle; add and subtract take longest. Run time is set by the
// binary gcd (one subtract, swap or shift per cycle, then one shift per cycle to restore
// common factors of two) and by the 64-step restoring divider, all running on one shared
// 66-bit adder/subtractor, plus one 32x32 multiplier used once per cycle. A new request
// may be issued in the same cycle that o_done is high.
module rational_arithmetic_unit
    import rau_pkg::*;
(
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               start,
    output logic              busy,
    input  wire  [2:0]        i_op,
    input  wire signed [31:0] i_num_a,
    input  wire signed [31:0] i_den_a,
    input  wire signed [31:0] i_num_b,
    input  wire signed [31:0] i_den_b,
    output logic              o_done,
    output logic signed [31:0] o_res_num,
    output logic [30:0]       o_res_den,
    output logic signed [1:0] o_order,
    output logic [1:0]        o_status
);

    // Sequencer states. GCD, GSHL and DIV are subroutines that return to r_ret.
    localparam t_state S_IDLE  = 5'd0;
    localparam t_state S_AQA   = 5'd1;
    localparam t_state S_AQB   = 5'd2;
    localparam t_state S_AQD   = 5'd3;
    localparam t_state S_AMUL1 = 5'd4;
    localparam t_state S_AMUL2 = 5'd5;
    localparam t_state S_AMUL3 = 5'd6;
    localparam t_state S_ASUM  = 5'd7;
    localparam t_state S_MMUL1 = 5'd8;
    localparam t_state S_MMUL2 = 5'd9;
    localparam t_state S_CCMP  = 5'd10;
    localparam t_state S_RST   = 5'd11;
    localparam t_state S_RDN   = 5'd12;
    localparam t_state S_RDD   = 5'd13;
    localparam t_state S_RCHK  = 5'd14;
    localparam t_state S_GCD   = 5'd15;
    localparam t_state S_GSHL  = 5'd16;
    localparam t_state S_DIV   = 5'd17;

    t_state r_state, n_state, r_ret, n_ret;
    logic [2:0]  r_op, n_op;
    logic [31:0] r_na, n_na, r_da, n_da, r_nb, n_nb, r_db, n_db;
    logic        r_sa, n_sa, r_sb, n_sb;
    logic [31:0] r_qa, n_qa, r_qb, n_qb;
    logic [63:0] r_n, n_n, r_d, n_d, r_t, n_t;
    logic        r_neg, n_neg, r_tneg, n_tneg;
    logic [63:0] r_u, n_u, r_v, n_v;
    logic [5:0]  r_k, n_k;
    logic [63:0] r_dvd, n_dvd, r_rem, n_rem;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_done, n_done;
    logic [31:0] r_res_num, n_res_num;
    logic [30:0] r_res_den, n_res_den;
    logic [1:0]  r_order, n_order, r_status, n_status;

    // Shared adder/subtractor; bit 65 of a subtraction is the borrow.
    logic [64:0] alu_a, alu_b;
    logic        alu_sub;
    logic [65:0] alu_res;
    logic        alu_borrow;

    // Shared multiplier.
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;

    // Operand magnitudes and signs at the request.
    logic [31:0] in_na, in_da, in_nb, in_db;
    logic        accept;
    logic [64:0] rem_sh;
    logic [63:0] lim_n;

    assign in_na  = i_num_a[31] ? (~i_num_a + 32'd1) : i_num_a;
    assign in_da  = i_den_a[31] ? (~i_den_a + 32'd1) : i_den_a;
    assign in_nb  = i_num_b[31] ? (~i_num_b + 32'd1) : i_num_b;
    assign in_db  = i_den_b[31] ? (~i_den_b + 32'd1) : i_den_b;
    assign accept = start && !busy;
    assign rem_sh = {r_rem, r_dvd[63]};
    assign lim_n  = r_neg ? RAU_LIM : (RAU_LIM - 64'd1);

    assign alu_res    = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                                : ({1'b0, alu_a} + {1'b0, alu_b});
    assign alu_borrow = alu_sub && alu_res[65];
    assign mul_p      = mul_a * mul_b;

    always_comb begin
        alu_a   = {1'b0, r_u};
        alu_b   = {1'b0, r_v};
        alu_sub = 1'b1;
        mul_a   = r_na;
        mul_b   = r_db;
        case (r_state)
            S_DIV: begin
                alu_a = rem_sh;
                alu_b = {1'b0, r_u};
            end
            S_ASUM: begin
                alu_a   = {1'b0, r_n};
                alu_b   = {1'b0, r_t};
                alu_sub = (r_neg != r_tneg);
            end
            S_CCMP: begin
                alu_a = {1'b0, r_n};
                alu_b = {1'b0, r_d};
            end
            S_AMUL1: begin
                mul_a = r_qa;
                mul_b = r_db;
            end
            S_AMUL2: begin
                mul_a = r_na;
                mul_b = r_qb;
            end
            S_AMUL3: begin
                mul_a = r_nb;
                mul_b = r_qa;
            end
            S_MMUL1: begin
                mul_a = r_na;
                mul_b = (r_op == OP_MUL) ? r_nb : r_db;
            end
            S_MMUL2: begin
                mul_a = r_da;
                mul_b = (r_op == OP_MUL) ? r_db : r_nb;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_ret     = r_ret;
        n_op      = r_op;
        n_na      = r_na;
        n_da      = r_da;
        n_nb      = r_nb;
        n_db      = r_db;
        n_sa      = r_sa;
        n_sb      = r_sb;
        n_qa      = r_qa;
        n_qb      = r_qb;
        n_n       = r_n;
        n_d       = r_d;
        n_t       = r_t;
        n_neg     = r_neg;
        n_tneg    = r_tneg;
        n_u       = r_u;
        n_v       = r_v;
        n_k       = r_k;
        n_dvd     = r_dvd;
        n_rem     = r_rem;
        n_cnt     = r_cnt;
        n_done    = 1'b0;
        n_res_num = r_res_num;
        n_res_den = r_res_den;
        n_order   = r_order;
        n_status  = r_status;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op  = i_op;
                    n_na  = in_na;
                    n_da  = in_da;
                    n_nb  = in_nb;
                    n_db  = in_db;
                    n_sa  = (i_num_a[31] != i_den_a[31]) && (in_na != 32'd0);
                    n_sb  = (i_num_b[31] != i_den_b[31]) && (in_nb != 32'd0);
                    n_res_num = 32'd0;
                    n_res_den = 31'd0;
                    n_order   = ORD_EQ;
                    if (i_op > OP_CMP || in_da == 32'd0
                            || (i_op != OP_RED && in_db == 32'd0)) begin
                        n_status = ST_INVAL;
                        n_done   = 1'b1;
                    end else if (i_op == OP_DIV && in_nb == 32'd0) begin
                        n_status = ST_ZDIV;
                        n_done   = 1'b1;
                    end else begin
                        case (i_op)
                            OP_RED: begin
                                n_n     = {32'd0, in_na};
                                n_d     = {32'd0, in_da};
                                n_neg   = n_sa;
                                n_state = S_RST;
                            end
                            OP_ADD, OP_SUB: begin
                                n_u     = {32'd0, in_da};
                                n_v     = {32'd0, in_db};
                                n_k     = 6'd0;
                                n_ret   = S_AQA;
                                n_state = S_GCD;
                            end
                            default: begin
                                n_state = S_MMUL1;
                            end
                        endcase
                    end
                end
            end
            S_AQA: begin
                n_dvd   = {32'd0, r_da};
                n_rem   = 64'd0;
                n_cnt   = 6'd0;
                n_ret   = S_AQB;
                n_state = S_DIV;
            end
            S_AQB: begin
                n_qa    = r_dvd[31:0];
                n_dvd   = {32'd0, r_db};
                n_rem   = 64'd0;
                n_cnt   = 6'd0;
                n_ret   = S_AQD;
                n_state = S_DIV;
            end
            S_AQD: begin
                n_qb    = r_dvd[31:0];
                n_state = S_AMUL1;
            end
            S_AMUL1: begin
                n_d     = mul_p;
                n_state = S_AMUL2;
            end
            S_AMUL2: begin
                n_n     = mul_p;
                n_neg   = r_sa;
                n_state = S_AMUL3;
            end
            S_AMUL3: begin
                n_t     = mul_p;
                n_tneg  = (r_nb != 32'd0) && ((r_op == OP_SUB) ? !r_sb : r_sb);
                n_state = S_ASUM;
            end
            S_ASUM: begin
                if (r_neg == r_tneg) begin
                    n_n     = alu_res[63:0];
                    n_state = S_RST;
                end else if (alu_borrow) begin
                    // Larger magnitude goes first; the subtraction runs next cycle.
                    n_n    = r_t;
                    n_t    = r_n;
                    n_neg  = r_tneg;
                    n_tneg = r_neg;
                end else begin
                    n_n     = alu_res[63:0];
                    if (alu_res[63:0] == 64'd0) begin
                        n_neg = 1'b0;
                    end
                    n_state = S_RST;
                end
            end
            S_MMUL1: begin
                n_n     = mul_p;
                n_state = S_MMUL2;
            end
            S_MMUL2: begin
                n_d     = mul_p;
                n_neg   = r_sa != r_sb;
                n_state = (r_op == OP_CMP) ? S_CCMP : S_RST;
            end
            S_CCMP: begin
                if (r_sa != r_sb) begin
                    n_order = r_sa ? ORD_LT : ORD_GT;
                end else if (alu_res[64:0] == 65'd0) begin
                    n_order = ORD_EQ;
                end else if (!alu_borrow != r_sa) begin
                    n_order = ORD_GT;
                end else begin
                    n_order = ORD_LT;
                end
                n_status = ST_OK;
                n_done   = 1'b1;
                n_state  = S_IDLE;
            end
            S_RST: begin
                if (r_n == 64'd0) begin
                    n_res_num = 32'd0;
                    n_res_den = 31'd1;
                    n_status  = ST_OK;
                    n_done    = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    n_u     = r_n;
                    n_v     = r_d;
                    n_k     = 6'd0;
                    n_ret   = S_RDN;
                    n_state = S_GCD;
                end
            end
            S_RDN: begin
                n_dvd   = r_n;
                n_rem   = 64'd0;
                n_cnt   = 6'd0;
                n_ret   = S_RDD;
                n_state = S_DIV;
            end
            S_RDD: begin
                n_n     = r_dvd;
                n_dvd   = r_d;
                n_rem   = 64'd0;
                n_cnt   = 6'd0;
                n_ret   = S_RCHK;
                n_state = S_DIV;
            end
            S_RCHK: begin
                if (r_dvd > (RAU_LIM - 64'd1) || r_n > lim_n) begin
                    n_res_num = 32'd0;
                    n_res_den = 31'd0;
                    n_status  = ST_OVFL;
                end else begin
                    n_res_num = r_neg ? (~r_n[31:0] + 32'd1) : r_n[31:0];
                    n_res_den = r_dvd[30:0];
                    n_status  = ST_OK;
                end
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            S_GCD: begin
                if (r_u == 64'd0 || r_v == 64'd0) begin
                    n_u     = r_u | r_v;
                    n_state = S_GSHL;
                end else if (!r_u[0] && !r_v[0]) begin
                    n_u = r_u >> 1;
                    n_v = r_v >> 1;
                    n_k = r_k + 6'd1;
                end else if (!r_u[0]) begin
                    n_u = r_u >> 1;
                end else if (!r_v[0]) begin
                    n_v = r_v >> 1;
                end else if (alu_borrow) begin
                    n_u = r_v;
                    n_v = r_u;
                end else begin
                    n_u = alu_res[64:1];
                end
            end
            S_GSHL: begin
                if (r_k == 6'd0) begin
                    n_state = r_ret;
                end else begin
                    n_u = r_u << 1;
                    n_k = r_k - 6'd1;
                end
            end
            S_DIV: begin
                if (!alu_borrow) begin
                    n_rem = alu_res[63:0];
                end else begin
                    n_rem = rem_sh[63:0];
                end
                n_dvd = {r_dvd[62:0], !alu_borrow};
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    n_state = r_ret;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_done  <= n_done;
        end
        r_op      <= n_op;
        r_na      <= n_na;
        r_da      <= n_da;
        r_nb      <= n_nb;
        r_db      <= n_db;
        r_sa      <= n_sa;
        r_sb      <= n_sb;
        r_qa      <= n_qa;
        r_qb      <= n_qb;
        r_n       <= n_n;
        r_d       <= n_d;
        r_t       <= n_t;
        r_neg     <= n_neg;
        r_tneg    <= n_tneg;
        r_u       <= n_u;
        r_v       <= n_v;
        r_k       <= n_k;
        r_dvd     <= n_dvd;
        r_rem     <= n_rem;
        r_cnt     <= n_cnt;
        r_res_num <= n_res_num;
        r_res_den <= n_res_den;
        r_order   <= n_order;
        r_status  <= n_status;
    end

    assign busy      = (r_state != S_IDLE);
    assign o_done    = r_done;
    assign o_res_num = r_res_num;
    assign o_res_den = r_res_den;
    assign o_order   = r_order;
    assign o_status  = r_status;

`ifndef SYNTH
    // Every accepted request either reports at once or keeps the block busy.
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (busy || o_done))
        else $error("request accepted but neither busy nor done");

    // A good rational result always carries a nonzero denominator.
    a_ok_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_OK && r_op != OP_CMP) |-> (o_res_den != 31'd0))
        else $error("ok result with zero denominator");

    // Error results clear every other field.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_OK)
        |-> (o_res_num == 32'sd0 && o_res_den == 31'd0 && o_order == ORD_EQ))
        else $error("error result with nonzero fields");

    // The divider never runs against a zero gcd.
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_u != 64'd0))
        else $error("division by zero gcd");
`endif

endmodule

`default_nettype wire
